FILE: rtl/assert_macros.svh
// assertion macros used by the rtl top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only while out of reset
`define PTEM_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// checked at every edge, reset included
`define PTEM_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

FILE: rtl/ptem_pkg.sv
// types and constants of the piece to extent mapper
package ptem_pkg;

    localparam int MAX_EXTENTS_DEF = 64;
    localparam int RESULT_CAP      = 64;
    localparam logic [26:0] PLEN_RESET = 27'd262144;

    localparam logic [1:0] OP_APPEND = 2'd0;
    localparam logic [1:0] OP_MAP    = 2'd1;
    localparam logic [1:0] OP_CLEAR  = 2'd2;

    localparam logic [1:0] STS_SEG   = 2'd0;
    localparam logic [1:0] STS_NONE  = 2'd1;
    localparam logic [1:0] STS_DONE  = 2'd2;
    localparam logic [1:0] STS_FULL  = 2'd3;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [39:0] extent_length;
        logic [30:0] piece_index;
        logic [26:0] piece_size;
    } t_cmd;

    typedef struct packed {
        logic [5:0]  extent_number;
        logic [39:0] extent_offset;
        logic [26:0] piece_offset;
        logic [26:0] segment_length;
        logic [1:0]  status;
        logic        last;
    } t_res;

    typedef struct packed {
        logic [46:0] stop;
        logic [45:0] start;
    } t_ext;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_ADD,
        ST_WALK,
        ST_FIN
    } t_state;

endpackage

FILE: rtl/ptem_ram.sv
// single port write, single port read ram with registered read data
module ptem_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/piece_to_extent_mapper_unit.sv
// top level of the piece to extent mapper
//
// command channel: i_cmd is taken at a rising edge with start high and busy low.
// append and clear words answer with one result word in the next cycle and leave
// busy low, so one such word can be taken every cycle while no map is running.
// a map word raises busy; the multiply and the end add come first, then the
// extent table ram is walked one entry a cycle (one read port, registered read
// data), the compare and subtract stages drain, and a final word is sent.
// segment words stream out at most one a cycle during the walk; the last one is
// held back and sent as the final word with o_res.last; with no hit the final
// word has status none and carries o_res.last.
// result channel: o_strobe marks each word for exactly one cycle; the receiver
// cannot stall, so no word waits.
// config: i_cfg_we writes the piece length; write it only while the block is idle, the block does not enforce it.
// reset: synchronous, active low; empties the table, zeroes the running total
// and sets the piece length to 262144. the ram itself is not cleared.
`include "assert_macros.svh"

module piece_to_extent_mapper_unit #(
    parameter int MAX_EXTENTS = ptem_pkg::MAX_EXTENTS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  ptem_pkg::t_cmd   i_cmd,
    input  logic             i_cfg_we,
    input  logic [26:0]      i_cfg_wdata,
    output logic             o_strobe,
    output ptem_pkg::t_res   o_res
);

    localparam int CNT_W = $clog2(MAX_EXTENTS + 1);
    localparam int AW    = (MAX_EXTENTS > 1) ? $clog2(MAX_EXTENTS) : 1;
    localparam int EXT_W = $bits(ptem_pkg::t_ext);

    ptem_pkg::t_state r_state, n_state;

    logic [CNT_W-1:0] r_count;
    logic [45:0]      r_rt;
    logic [26:0]      r_plen;

    logic [30:0]      r_pidx;
    logic [26:0]      r_psize;
    logic [57:0]      r_pstart;
    logic [58:0]      r_pend;

    logic [CNT_W-1:0] r_addr;
    logic             r_rd_v;
    logic [5:0]       r_rd_num;
    logic [6:0]       r_hits;

    logic             r_s1_v;
    logic             r_s1_hit;
    logic [5:0]       r_s1_num;
    logic [57:0]      r_s1_ws;
    logic [58:0]      r_s1_we;
    logic [45:0]      r_s1_fstart;

    logic             r_pnd_v;
    ptem_pkg::t_res   r_pnd;
    logic             r_out_v;
    ptem_pkg::t_res   r_out;

    logic             w_acc;
    logic             w_full;
    logic             w_issue;
    logic             w_ram_we;
    logic             w_out_v;
    ptem_pkg::t_ext   w_wext;
    ptem_pkg::t_ext   w_rext;
    logic [EXT_W-1:0] w_rdata;
    logic [31:0]      w_cnt32;
    logic [31:0]      w_addr32;
    logic [57:0]      w_prod;
    logic [58:0]      w_fend;
    logic [58:0]      w_fstart;
    logic             w_hit;
    logic [57:0]      w_ws;
    logic [58:0]      w_we;
    logic [57:0]      w_eoff;
    logic [57:0]      w_poff;
    logic [58:0]      w_len;
    ptem_pkg::t_res   w_seg;
    ptem_pkg::t_res   w_pnd_last;

    function automatic ptem_pkg::t_res flag_res(logic [1:0] status, logic [5:0] num);
        ptem_pkg::t_res res;
        res                = '0;
        res.extent_number  = num;
        res.status         = status;
        res.last           = 1'b1;
        return res;
    endfunction

    assign busy     = (r_state != ptem_pkg::ST_IDLE);
    assign w_acc    = start && !busy;
    assign w_full   = (r_count == CNT_W'(MAX_EXTENTS));
    assign w_issue  = (r_state == ptem_pkg::ST_WALK) && (r_addr < r_count);
    assign w_ram_we = w_acc && (i_cmd.opcode == ptem_pkg::OP_APPEND) && !w_full;
    assign w_cnt32  = 32'(r_count);
    assign w_addr32 = 32'(r_addr);

    assign w_out_v  = (w_acc && ((i_cmd.opcode == ptem_pkg::OP_APPEND)
                                 || (i_cmd.opcode == ptem_pkg::OP_CLEAR)))
                      || ((r_state == ptem_pkg::ST_WALK) && r_s1_v && r_s1_hit && r_pnd_v)
                      || (r_state == ptem_pkg::ST_FIN);

    assign w_wext.start = r_rt;
    assign w_wext.stop  = {1'b0, r_rt} + {7'b0, i_cmd.extent_length};

    ptem_ram #(
        .WIDTH (EXT_W),
        .DEPTH (MAX_EXTENTS),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata (w_wext),
        .i_re    (w_issue),
        .i_raddr (r_addr[AW-1:0]),
        .o_rdata (w_rdata)
    );

    assign w_rext = w_rdata;

    // piece start, overlap test and clipped window
    assign w_prod   = {27'b0, r_pidx} * {31'b0, r_plen};
    assign w_fstart = {13'b0, w_rext.start};
    assign w_fend   = {12'b0, w_rext.stop};
    assign w_hit    = !((r_pend <= w_fstart) || ({1'b0, r_pstart} >= w_fend));
    assign w_ws     = ({1'b0, r_pstart} > w_fstart) ? r_pstart : w_fstart[57:0];
    assign w_we     = (r_pend < w_fend) ? r_pend : w_fend;

    // segment fields from the clipped window
    assign w_eoff = r_s1_ws - {12'b0, r_s1_fstart};
    assign w_poff = r_s1_ws - r_pstart;
    assign w_len  = r_s1_we - {1'b0, r_s1_ws};

    always_comb begin
        w_seg                = '0;
        w_seg.extent_number  = r_s1_num;
        w_seg.extent_offset  = w_eoff[39:0];
        w_seg.piece_offset   = w_poff[26:0];
        w_seg.segment_length = w_len[26:0];
        w_seg.status         = ptem_pkg::STS_SEG;
        w_seg.last           = 1'b0;
    end

    always_comb begin
        w_pnd_last      = r_pnd;
        w_pnd_last.last = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ptem_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ptem_pkg::ST_IDLE: begin
                if (w_acc && (i_cmd.opcode == ptem_pkg::OP_MAP)) begin
                    n_state = ptem_pkg::ST_MUL;
                end
            end
            ptem_pkg::ST_MUL:  n_state = ptem_pkg::ST_ADD;
            ptem_pkg::ST_ADD:  n_state = ptem_pkg::ST_WALK;
            ptem_pkg::ST_WALK: begin
                if (!w_issue && !r_rd_v && !r_s1_v) begin
                    n_state = ptem_pkg::ST_FIN;
                end
            end
            ptem_pkg::ST_FIN:  n_state = ptem_pkg::ST_IDLE;
            default:           n_state = ptem_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_rt     <= '0;
            r_plen   <= ptem_pkg::PLEN_RESET;
            r_addr   <= '0;
            r_rd_v   <= 1'b0;
            r_s1_v   <= 1'b0;
            r_s1_hit <= 1'b0;
            r_hits   <= '0;
            r_pnd_v  <= 1'b0;
            r_out_v  <= 1'b0;
        end else begin
            r_out_v  <= w_out_v;
            r_rd_v   <= w_issue;
            r_s1_v   <= r_rd_v;
            r_s1_hit <= r_rd_v && w_hit && (r_hits < 7'(ptem_pkg::RESULT_CAP));
            if (i_cfg_we) begin
                r_plen <= i_cfg_wdata;
            end
            if (r_rd_v) begin
                r_s1_num    <= r_rd_num;
                r_s1_ws     <= w_ws;
                r_s1_we     <= w_we;
                r_s1_fstart <= w_rext.start;
                if (w_hit && (r_hits < 7'(ptem_pkg::RESULT_CAP))) begin
                    r_hits <= r_hits + 7'd1;
                end
            end
            case (r_state)
                ptem_pkg::ST_IDLE: begin
                    if (w_acc) begin
                        case (i_cmd.opcode)
                            ptem_pkg::OP_APPEND: begin
                                if (w_full) begin
                                    r_out <= flag_res(ptem_pkg::STS_FULL, 6'd0);
                                end else begin
                                    r_out   <= flag_res(ptem_pkg::STS_DONE, w_cnt32[5:0]);
                                    r_count <= r_count + CNT_W'(1);
                                    r_rt    <= r_rt + {6'b0, i_cmd.extent_length};
                                end
                            end
                            ptem_pkg::OP_MAP: begin
                                r_pidx  <= i_cmd.piece_index;
                                r_psize <= i_cmd.piece_size;
                                r_addr  <= '0;
                                r_hits  <= '0;
                                r_pnd_v <= 1'b0;
                            end
                            ptem_pkg::OP_CLEAR: begin
                                r_out   <= flag_res(ptem_pkg::STS_DONE, 6'd0);
                                r_count <= '0;
                                r_rt    <= '0;
                            end
                            default: ;
                        endcase
                    end
                end
                ptem_pkg::ST_MUL: r_pstart <= w_prod;
                ptem_pkg::ST_ADD: r_pend <= {1'b0, r_pstart} + {32'b0, r_psize};
                ptem_pkg::ST_WALK: begin
                    if (w_issue) begin
                        r_rd_num <= w_addr32[5:0];
                        r_addr   <= r_addr + CNT_W'(1);
                    end
                    // hold one segment back so the final one can carry last
                    if (r_s1_v && r_s1_hit) begin
                        if (r_pnd_v) begin
                            r_out <= r_pnd;
                        end
                        r_pnd   <= w_seg;
                        r_pnd_v <= 1'b1;
                    end
                end
                ptem_pkg::ST_FIN: begin
                    r_pnd_v <= 1'b0;
                    if (r_pnd_v) begin
                        r_out <= w_pnd_last;
                    end else begin
                        r_out <= flag_res(ptem_pkg::STS_NONE, 6'd0);
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_strobe = r_out_v;
    assign o_res    = r_out;

    `PTEM_ASSERT(a_count_range, i_clk, i_rst_n, r_count <= CNT_W'(MAX_EXTENTS), "entry count above table depth")
    `PTEM_ASSERT(a_fin_last, i_clk, i_rst_n, (r_state == ptem_pkg::ST_FIN) |=> (o_strobe && o_res.last), "map did not end with a last word")
    `PTEM_ASSERT(a_busy_map, i_clk, i_rst_n, $rose(busy) |-> $past(start && (i_cmd.opcode == ptem_pkg::OP_MAP)), "busy without a map word")
    `PTEM_ASSERT(a_quick_reply, i_clk, i_rst_n, (w_acc && ((i_cmd.opcode == ptem_pkg::OP_APPEND) || (i_cmd.opcode == ptem_pkg::OP_CLEAR))) |=> (o_strobe && o_res.last), "append or clear gave no word")

endmodule

FILE: sim/ptem_checker.sv
// checker for the piece to extent mapper: watches both channels, predicts and compares words
module ptem_checker
    import ptem_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    input  logic        busy,
    input  t_cmd        i_cmd,
    input  logic        i_cfg_we,
    input  logic [26:0] i_cfg_wdata,
    input  logic        i_strobe,
    input  t_res        i_res,
    output int          o_fail_count,
    output int          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [45:0]  ext_base [MAX_EXTENTS_DEF];
    logic [39:0]  ext_len [MAX_EXTENTS_DEF];
    int unsigned  tbl_count = 0;
    logic [45:0]  byte_total = '0;
    logic [26:0]  plen = PLEN_RESET;
    t_res         due_words [$];
    int           fails = 0;

    function automatic t_res word_of(input logic [5:0] num, input logic [39:0] eoff,
                                     input logic [26:0] poff, input logic [26:0] len,
                                     input logic [1:0] sts, input logic lst);
        t_res w;
        w.extent_number = num;
        w.extent_offset = eoff;
        w.piece_offset = poff;
        w.segment_length = len;
        w.status = sts;
        w.last = lst;
        return w;
    endfunction

    task automatic expect_word(input t_res w);
        due_words = {due_words, w};
    endtask

    task automatic map_command(input t_cmd c);
        logic [63:0] p_lo, p_hi, e_lo, e_hi, w_lo, w_hi;
        t_res        held;
        bit          have_held;
        int          hits;
        have_held = 1'b0;
        hits = 0;
        case (c.opcode)
            OP_APPEND: begin
                if (tbl_count >= MAX_EXTENTS_DEF) begin
                    expect_word(word_of('0, '0, '0, '0, STS_FULL, 1'b1));
                end else begin
                    ext_base[tbl_count] = byte_total;
                    ext_len[tbl_count] = c.extent_length;
                    expect_word(word_of(6'(tbl_count), '0, '0, '0, STS_DONE, 1'b1));
                    tbl_count++;
                    byte_total = byte_total + 46'(c.extent_length);
                end
            end
            OP_CLEAR: begin
                tbl_count = 0;
                byte_total = '0;
                expect_word(word_of('0, '0, '0, '0, STS_DONE, 1'b1));
            end
            OP_MAP: begin
                p_lo = 64'(c.piece_index) * 64'(plen);
                p_hi = p_lo + 64'(c.piece_size);
                for (int i = 0; i < tbl_count; i++) begin
                    e_lo = 64'(ext_base[i]);
                    e_hi = e_lo + 64'(ext_len[i]);
                    if (p_hi > e_lo && p_lo < e_hi && hits < RESULT_CAP) begin
                        w_lo = (p_lo > e_lo) ? p_lo : e_lo;
                        w_hi = (p_hi < e_hi) ? p_hi : e_hi;
                        if (have_held)
                            expect_word(held);
                        held = word_of(6'(i), 40'(w_lo - e_lo), 27'(w_lo - p_lo),
                                       27'(w_hi - w_lo), STS_SEG, 1'b0);
                        have_held = 1'b1;
                        hits++;
                    end
                end
                if (have_held) begin
                    held.last = 1'b1;
                    expect_word(held);
                end else begin
                    expect_word(word_of('0, '0, '0, '0, STS_NONE, 1'b1));
                end
            end
            default: ;
        endcase
    endtask

    task automatic report_field(input string name, input logic [39:0] want,
                                input logic [39:0] got);
        if (want !== got)
            $display("%0t: %s expected %0h got %0h", $time, name, want, got);
    endtask

    task automatic check_word(input t_res got);
        t_res want;
        if (due_words.size() == 0) begin
            fails++;
            $display("%0t: result word with nothing expected, expected none got %h",
                     $time, got);
            return;
        end
        want = due_words.pop_front();
        if (got !== want) begin
            fails++;
            report_field("extent_number", 40'(want.extent_number), 40'(got.extent_number));
            report_field("extent_offset", want.extent_offset, got.extent_offset);
            report_field("piece_offset", 40'(want.piece_offset), 40'(got.piece_offset));
            report_field("segment_length", 40'(want.segment_length),
                         40'(got.segment_length));
            report_field("status", 40'(want.status), 40'(got.status));
            report_field("last", 40'(want.last), 40'(got.last));
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            tbl_count = 0;
            byte_total = '0;
            plen = PLEN_RESET;
        end else begin
            if (i_strobe)
                check_word(i_res);
            if (i_cfg_we)
                plen = i_cfg_wdata;
            if (start && !busy)
                map_command(i_cmd);
        end
        o_fail_count <= fails;
        o_pending <= due_words.size();
    end

endmodule

FILE: sim/tb_top.sv
// testbench top of the piece to extent mapper: stimulus, config writes and verdict
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import ptem_pkg::*;

    localparam int          CLK_HALF      = 6;
    localparam int          RESET_CYCLES  = 4;
    localparam int          SETTLE_CYCLES = 12;
    localparam int          CYCLE_LIMIT   = 400000;
    localparam int          RANDOM_WORDS  = 500;
    localparam int          PHASE_WORDS   = 100;
    localparam logic [1:0]  OP_UNUSED     = 2'd3;
    localparam logic [26:0] PLEN_TOP      = 27'd67108864;
    localparam logic [39:0] LEN_TOP       = 40'hFF_FFFF_FFFF;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    t_cmd        i_cmd = '0;
    logic        i_cfg_we = 1'b0;
    logic [26:0] i_cfg_wdata = '0;
    logic        o_strobe;
    t_res        o_res;
    int          fail_count;
    int          pending;
    int          cycle_count = 0;

    int          words_sent = 0;
    int unsigned tbl_n = 0;
    logic [63:0] tbl_total = '0;
    logic [26:0] cur_plen = PLEN_RESET;
    bit          steady = 1'b0;

    piece_to_extent_mapper_unit DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_cmd       (i_cmd),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_strobe    (o_strobe),
        .o_res       (o_res)
    );

    ptem_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_cmd        (i_cmd),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_strobe     (o_strobe),
        .i_res        (o_res),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always #(CLK_HALF) i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    function automatic int pick_gap();
        int r;
        if (steady)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [39:0] rand40();
        logic [63:0] r;
        r = {$urandom, $urandom};
        return r[39:0];
    endfunction

    task automatic issue(input logic [1:0] op, input logic [39:0] len,
                         input logic [30:0] idx, input logic [26:0] size);
        t_cmd w;
        int   gap;
        w.opcode = op;
        w.extent_length = len;
        w.piece_index = idx;
        w.piece_size = size;
        gap = pick_gap();
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        i_cmd <= w;
        do @(posedge i_clk); while (busy);
        if (op == OP_APPEND && tbl_n < MAX_EXTENTS_DEF) begin
            tbl_n++;
            tbl_total = tbl_total + 64'(len);
        end else if (op == OP_CLEAR) begin
            tbl_n = 0;
            tbl_total = '0;
        end
        if (op != OP_UNUSED)
            words_sent++;
    endtask

    task automatic noise_word();
        issue(2'($urandom_range(0, 3)), rand40(), 31'($urandom), 27'($urandom));
    endtask

    task automatic settle();
        start <= 1'b0;
        do @(posedge i_clk); while (pending != 0 || busy);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_piece_length(input logic [26:0] v);
        settle();
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        cur_plen = v;
    endtask

    initial begin
        int unsigned n_ext, n_map, shift;
        int          next_phase, first_random;
        logic [63:0] base, unit, spot, sz;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // default piece length, empty table first
        issue(OP_MAP, '0, '0, 27'd100);
        issue(OP_UNUSED, LEN_TOP, '1, '1);
        issue(OP_APPEND, '0, '0, '0);
        issue(OP_APPEND, 40'd1000, '0, '0);
        issue(OP_APPEND, '0, '0, '0);
        issue(OP_APPEND, 40'd300000, '0, '0);
        issue(OP_APPEND, LEN_TOP, '0, '0);
        issue(OP_MAP, '0, 31'd0, 27'd0);
        issue(OP_MAP, '0, 31'd0, 27'd262144);
        issue(OP_MAP, '0, 31'd1, 27'd262144);
        issue(OP_MAP, '0, '1, PLEN_TOP);
        issue(OP_MAP, '0, 31'd4194304, PLEN_TOP);
        issue(OP_CLEAR, '0, '0, '0);

        set_piece_length(27'd1);
        issue(OP_APPEND, 40'd5, '0, '0);
        issue(OP_APPEND, 40'd5, '0, '0);
        issue(OP_MAP, '0, 31'd3, 27'd4);

        // zero piece length puts every piece at byte 0
        set_piece_length('0);
        issue(OP_MAP, '0, 31'd12345, 27'd7);

        set_piece_length(PLEN_TOP);
        issue(OP_CLEAR, '0, '0, '0);
        issue(OP_APPEND, LEN_TOP, '0, '0);
        issue(OP_APPEND, LEN_TOP, '0, '0);
        issue(OP_APPEND, LEN_TOP, '0, '0);
        issue(OP_MAP, '0, 31'd16383, PLEN_TOP);
        issue(OP_MAP, '0, 31'd49151, PLEN_TOP);

        first_random = words_sent;
        next_phase = words_sent;
        while (words_sent - first_random < RANDOM_WORDS) begin
            if (words_sent >= next_phase) begin
                case ($urandom_range(0, 5))
                    0: set_piece_length(27'd1);
                    1: set_piece_length(PLEN_TOP);
                    2: set_piece_length('0);
                    3: set_piece_length(27'($urandom_range(2, 4096)));
                    4: set_piece_length(27'($urandom_range(1, 67108864)));
                    default: set_piece_length(PLEN_RESET);
                endcase
                next_phase = words_sent + PHASE_WORDS;
            end
            steady = ($urandom_range(0, 4) == 0);
            base = (cur_plen == 0) ? 64'd4096 : 64'(cur_plen);
            shift = $urandom_range(0, 6);
            unit = base >> shift;
            if (unit == 0)
                unit = 1;

            issue(OP_CLEAR, rand40(), 31'($urandom), 27'($urandom));
            n_ext = ($urandom_range(0, 3) == 0) ? 64 + $urandom_range(0, 2)
                                                : $urandom_range(1, 12);
            repeat (n_ext) begin
                if ($urandom_range(0, 9) == 0)
                    noise_word();
                issue(OP_APPEND,
                      ($urandom_range(0, 7) == 0) ? 40'd0
                                                  : 40'($urandom_range(1, 32'(2 * unit))),
                      31'($urandom), 27'($urandom));
            end

            n_map = $urandom_range(4, 16);
            repeat (n_map) begin
                if ($urandom_range(0, 9) == 0)
                    noise_word();
                spot = {$urandom, $urandom} % (tbl_total + 1);
                case ($urandom_range(0, 9))
                    0: sz = '0;
                    1: sz = 64'(PLEN_TOP);
                    2: sz = tbl_total;
                    default: sz = 64'($urandom_range(1, 32'(3 * unit)));
                endcase
                if (sz > 64'(PLEN_TOP))
                    sz = 64'(PLEN_TOP);
                issue(OP_MAP, rand40(),
                      31'((cur_plen == 0) ? 64'($urandom) : spot / 64'(cur_plen)),
                      27'(sz));
                if ($urandom_range(0, 19) == 0)
                    settle();
            end
        end

        settle();
        if (fail_count == 0 && pending == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
